@@ hw/rtl/etmb_pkg.sv @@
// ---------------------------------------------------------------------------
// etmb_pkg
// Shared types and constants for the Euler TRS matrix builder.
// ---------------------------------------------------------------------------
package etmb_pkg;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int SINE_DEPTH_DEF = 256;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int ANGLE_W        = 16;
  localparam int DATA_W         = 32;
  localparam int TRIG_W         = 26;

  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  typedef struct packed {
    logic       valid;
    logic       rot_only;
  } etmb_ctl_t;

endpackage

@@ hw/rtl/etmb_trig.sv @@
// ---------------------------------------------------------------------------
// etmb_trig
// Registered sine and cosine lookup for one binary angle.
// ---------------------------------------------------------------------------
module etmb_trig import etmb_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF,
  parameter int SINE_DEPTH = SINE_DEPTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic [ANGLE_W-1:0]       angle,
  output logic signed [TRIG_W-1:0] sin_r,
  output logic signed [TRIG_W-1:0] cos_r
);

  localparam int QW = ANGLE_BITS - 2;
  localparam int IW = $clog2(SINE_DEPTH + 1);

  logic [TRIG_W-1:0] tab [SINE_DEPTH+1];

  // Quarter-wave table: a Taylor series in Q30 with truncation, then rounding.
  for (genvar k = 0; k <= SINE_DEPTH; k++) begin : g_tab
    localparam logic [63:0] X  = (PI_Q30 * 64'(k) + 64'(SINE_DEPTH))
                                 / (64'd2 * 64'(SINE_DEPTH));
    localparam logic [63:0] X2 = (X * X + (64'd1 << 29)) >> 30;
    localparam logic [63:0] T1 = ((X * X2) >> 30) / 64'd6;
    localparam logic [63:0] T2 = ((T1 * X2) >> 30) / 64'd20;
    localparam logic [63:0] T3 = ((T2 * X2) >> 30) / 64'd42;
    localparam logic [63:0] T4 = ((T3 * X2) >> 30) / 64'd72;
    localparam logic [63:0] T5 = ((T4 * X2) >> 30) / 64'd110;
    localparam logic [63:0] T6 = ((T5 * X2) >> 30) / 64'd156;
    localparam logic [63:0] T7 = ((T6 * X2) >> 30) / 64'd210;
    localparam logic [63:0] T8 = ((T7 * X2) >> 30) / 64'd272;
    localparam logic signed [63:0] SUM = $signed(X) - $signed(T1) + $signed(T2)
                                         - $signed(T3) + $signed(T4) - $signed(T5)
                                         + $signed(T6) - $signed(T7) + $signed(T8);
    localparam logic [63:0] POS = (SUM < 0) ? 64'd0 : $unsigned(SUM);
    localparam logic [63:0] ENT = (POS + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
    assign tab[k] = ENT[TRIG_W-1:0];
  end

  function automatic logic signed [TRIG_W-1:0] look(input logic [ANGLE_BITS-1:0] a);
    logic [1:0]     q;
    logic [QW-1:0]  r;
    logic [QW+IW:0] prod;
    logic [IW-1:0]  idx;
    logic [IW-1:0]  sel;
    logic [TRIG_W-1:0] v;
    q = a[ANGLE_BITS-1 -: 2];
    r = a[QW-1:0];
    prod = (QW+IW+1)'(r) * (QW+IW+1)'(SINE_DEPTH);
    idx = IW'(prod >> QW);
    sel = q[0] ? IW'(SINE_DEPTH) - idx : idx;
    v = tab[sel];
    return q[1] ? -$signed(v) : $signed(v);
  endfunction

  logic [ANGLE_BITS-1:0] a_s;
  logic [ANGLE_BITS-1:0] a_c;

  assign a_s = ANGLE_BITS'(angle);
  assign a_c = a_s + (ANGLE_BITS'(1) << QW);

  always_ff @(posedge clk) begin
    sin_r <= look(a_s);
    cos_r <= look(a_c);
  end

endmodule

@@ hw/rtl/etmb_fmul.sv @@
// ---------------------------------------------------------------------------
// etmb_fmul
// Registered fixed-point product with round-half-up and floor shift.
// ---------------------------------------------------------------------------
module etmb_fmul import etmb_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int AW = DATA_W,
  parameter int BW = TRIG_W,
  parameter int OW = 40
) (
  input  logic                 clk,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic signed [OW-1:0] p_r
);

  logic signed [AW+BW-1:0] prod;
  logic signed [AW+BW-1:0] rnd;

  assign prod = (AW+BW)'(a) * (AW+BW)'(b);
  assign rnd  = prod + ((AW+BW)'(1) <<< (FRAC_BITS - 1));

  always_ff @(posedge clk) begin
    p_r <= OW'(rnd >>> FRAC_BITS);
  end

endmodule

@@ hw/rtl/euler_trs_matrix_builder_top.sv @@
// ---------------------------------------------------------------------------
// euler_trs_matrix_builder_top
// Builds the 4x4 model matrix T*S*(Rx*Ry*Rz) or the rotation alone.
// ---------------------------------------------------------------------------
// A start beat is taken in any cycle in which busy is low; it yields four row
// beats on consecutive cycles, row 0 first. A hold counter raises busy after
// each start and drops it before the rows of that transform appear, so a new
// start can enter while earlier ones are in the pipeline. The receiver must take
// every row beat as it appears, since the block cannot be stalled.
module euler_trs_matrix_builder_top import etmb_pkg::*; #(
  parameter int ANGLE_BITS       = ANGLE_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF,
  parameter int FRAC_BITS        = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic                     in_action,
  input  logic signed [DATA_W-1:0] in_pos_x,
  input  logic signed [DATA_W-1:0] in_pos_y,
  input  logic signed [DATA_W-1:0] in_pos_z,
  input  logic [ANGLE_W-1:0]       in_angle_x,
  input  logic [ANGLE_W-1:0]       in_angle_y,
  input  logic [ANGLE_W-1:0]       in_angle_z,
  input  logic signed [DATA_W-1:0] in_scale_x,
  input  logic signed [DATA_W-1:0] in_scale_y,
  input  logic signed [DATA_W-1:0] in_scale_z,
  output logic                     out_valid,
  output logic [1:0]               out_row_index,
  output logic signed [DATA_W-1:0] out_elem_0,
  output logic signed [DATA_W-1:0] out_elem_1,
  output logic signed [DATA_W-1:0] out_elem_2,
  output logic signed [DATA_W-1:0] out_elem_3,
  output logic                     out_last_row
);

  localparam int PW = 40;
  localparam int DEPTH = 6;
  localparam logic signed [PW-1:0] SMAX = PW'(64'sd2147483647);
  localparam logic signed [PW-1:0] SMIN = -PW'(64'sd2147483648);

  function automatic logic signed [DATA_W-1:0] sat(input logic signed [PW-1:0] v);
    if (v > SMAX) begin
      return DATA_W'(SMAX);
    end else if (v < SMIN) begin
      return DATA_W'(SMIN);
    end
    return DATA_W'(v);
  endfunction

  logic [1:0] hold_r;
  logic [1:0] hold_nxt;
  logic       acc;

  assign acc  = start && !busy;
  assign busy = (hold_r != 2'd0);
  assign hold_nxt = acc ? 2'd3 : (busy ? hold_r - 2'd1 : 2'd0);

  etmb_ctl_t ctl_r [DEPTH];
  logic signed [DATA_W-1:0] pos_r [5][3];
  logic signed [DATA_W-1:0] scl_r [4][3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 2'd0;
      for (int i = 0; i < DEPTH; i++) begin
        ctl_r[i] <= '0;
      end
    end else begin
      hold_r <= hold_nxt;
      ctl_r[0].valid    <= acc;
      ctl_r[0].rot_only <= in_action;
      for (int i = 1; i < DEPTH; i++) begin
        ctl_r[i] <= ctl_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r[0][0] <= in_pos_x;
    pos_r[0][1] <= in_pos_y;
    pos_r[0][2] <= in_pos_z;
    scl_r[0][0] <= in_scale_x;
    scl_r[0][1] <= in_scale_y;
    scl_r[0][2] <= in_scale_z;
    for (int i = 1; i < 5; i++) begin
      pos_r[i] <= pos_r[i-1];
    end
    for (int i = 1; i < 4; i++) begin
      scl_r[i] <= scl_r[i-1];
    end
  end

  // Stage 1: trig lookup.
  logic signed [TRIG_W-1:0] sa, ca, sb, cb, sc, cc;
  etmb_trig #(.ANGLE_BITS(ANGLE_BITS), .SINE_DEPTH(SINE_TABLE_DEPTH), .FRAC_BITS(FRAC_BITS))
    u_tx (.clk(clk), .angle(in_angle_x), .sin_r(sa), .cos_r(ca));
  etmb_trig #(.ANGLE_BITS(ANGLE_BITS), .SINE_DEPTH(SINE_TABLE_DEPTH), .FRAC_BITS(FRAC_BITS))
    u_ty (.clk(clk), .angle(in_angle_y), .sin_r(sb), .cos_r(cb));
  etmb_trig #(.ANGLE_BITS(ANGLE_BITS), .SINE_DEPTH(SINE_TABLE_DEPTH), .FRAC_BITS(FRAC_BITS))
    u_tz (.clk(clk), .angle(in_angle_z), .sin_r(sc), .cos_r(cc));

  // Stage 2: first products.
  logic signed [PW-1:0] sasb, casb, cbcc, cbsc, sacb, cacb, sasc, sacc, casc, cacc;
  logic signed [TRIG_W-1:0] sc2_r, cc2_r, sb2_r;
  always_ff @(posedge clk) begin
    sc2_r <= sc;
    cc2_r <= cc;
    sb2_r <= sb;
  end
  etmb_fmul #(.FRAC_BITS(FRAC_BITS), .AW(TRIG_W), .BW(TRIG_W), .OW(PW))
    u_m0 (.clk(clk), .a(sa), .b(sb), .p_r(sasb));
  etmb_fmul #(.FRAC_BITS(FRAC_BITS), .AW(TRIG_W), .BW(TRIG_W), .OW(PW))
    u_m1 (.clk(clk), .a(ca), .b(sb), .p_r(casb));
  etmb_fmul #(.FRAC_BITS(FRAC_BITS), .AW(TRIG_W), .BW(TRIG_W), .OW(PW))
    u_m2 (.clk(clk), .a(cb), .b(cc), .p_r(cbcc));
  etmb_fmul #(.FRAC_BITS(FRAC_BITS), .AW(TRIG_W), .BW(TRIG_W), .OW(PW))
    u_m3 (.clk(clk), .a(cb), .b(sc), .p_r(cbsc));
  etmb_fmul #(.FRAC_BITS(FRAC_BITS), .AW(TRIG_W), .BW(TRIG_W), .OW(PW))
    u_m4 (.clk(clk), .a(sa), .b(cb), .p_r(sacb));
  etmb_fmul #(.FRAC_BITS(FRAC_BITS), .AW(TRIG_W), .BW(TRIG_W), .OW(PW))
    u_m5 (.clk(clk), .a(ca), .b(cb), .p_r(cacb));
  etmb_fmul #(.FRAC_BITS(FRAC_BITS), .AW(TRIG_W), .BW(TRIG_W), .OW(PW))
    u_m6 (.clk(clk), .a(sa), .b(sc), .p_r(sasc));
  etmb_fmul #(.FRAC_BITS(FRAC_BITS), .AW(TRIG_W), .BW(TRIG_W), .OW(PW))
    u_m7 (.clk(clk), .a(sa), .b(cc), .p_r(sacc));
  etmb_fmul #(.FRAC_BITS(FRAC_BITS), .AW(TRIG_W), .BW(TRIG_W), .OW(PW))
    u_m8 (.clk(clk), .a(ca), .b(sc), .p_r(casc));
  etmb_fmul #(.FRAC_BITS(FRAC_BITS), .AW(TRIG_W), .BW(TRIG_W), .OW(PW))
    u_m9 (.clk(clk), .a(ca), .b(cc), .p_r(cacc));

  // Stage 3: second products; sasb and casb never exceed one in magnitude.
  logic signed [PW-1:0] p_sasbcc, p_sasbsc, p_casbcc, p_casbsc;
  logic signed [PW-1:0] r3 [9];
  etmb_fmul #(.FRAC_BITS(FRAC_BITS), .AW(TRIG_W), .BW(TRIG_W), .OW(PW))
    u_n0 (.clk(clk), .a(TRIG_W'(sasb)), .b(cc2_r), .p_r(p_sasbcc));
  etmb_fmul #(.FRAC_BITS(FRAC_BITS), .AW(TRIG_W), .BW(TRIG_W), .OW(PW))
    u_n1 (.clk(clk), .a(TRIG_W'(sasb)), .b(sc2_r), .p_r(p_sasbsc));
  etmb_fmul #(.FRAC_BITS(FRAC_BITS), .AW(TRIG_W), .BW(TRIG_W), .OW(PW))
    u_n2 (.clk(clk), .a(TRIG_W'(casb)), .b(cc2_r), .p_r(p_casbcc));
  etmb_fmul #(.FRAC_BITS(FRAC_BITS), .AW(TRIG_W), .BW(TRIG_W), .OW(PW))
    u_n3 (.clk(clk), .a(TRIG_W'(casb)), .b(sc2_r), .p_r(p_casbsc));
  always_ff @(posedge clk) begin
    r3[0] <= cbcc;
    r3[1] <= -cbsc;
    r3[2] <= PW'(sb2_r);
    r3[3] <= casc;
    r3[4] <= cacc;
    r3[5] <= -sacb;
    r3[6] <= sasc;
    r3[7] <= sacc;
    r3[8] <= cacb;
  end

  // Stage 4: rotation entries.
  logic signed [PW-1:0] rot_r [9];
  always_ff @(posedge clk) begin
    rot_r[0] <= r3[0];
    rot_r[1] <= r3[1];
    rot_r[2] <= r3[2];
    rot_r[3] <= p_sasbcc + r3[3];
    rot_r[4] <= r3[4] - p_sasbsc;
    rot_r[5] <= r3[5];
    rot_r[6] <= r3[6] - p_casbcc;
    rot_r[7] <= p_casbsc + r3[7];
    rot_r[8] <= r3[8];
  end

  // Stage 5: scaling; rotation entries stay below 2^(FRAC_BITS+2).
  logic signed [PW-1:0] sm [9];
  for (genvar i = 0; i < 3; i++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_col
      etmb_fmul #(.FRAC_BITS(FRAC_BITS), .AW(DATA_W), .BW(TRIG_W), .OW(PW))
        u_s (.clk(clk), .a(scl_r[3][i]), .b(TRIG_W'(rot_r[i*3+j])), .p_r(sm[i*3+j]));
    end
  end
  logic signed [PW-1:0] rot5_r [9];
  always_ff @(posedge clk) begin
    rot5_r <= rot_r;
  end

  // Stage 6: select, saturate and capture all rows.
  logic signed [DATA_W-1:0] mat_r [4][4];
  logic signed [DATA_W-1:0] one;
  assign one = DATA_W'(1) <<< FRAC_BITS;
  always_ff @(posedge clk) begin
    if (ctl_r[4].valid) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          mat_r[i][j] <= sat(ctl_r[4].rot_only ? rot5_r[i*3+j] : sm[i*3+j]);
        end
        mat_r[i][3] <= ctl_r[4].rot_only ? '0 : pos_r[4][i];
        mat_r[3][i] <= '0;
      end
      mat_r[3][3] <= one;
    end
  end

  // Row serializer.
  logic [1:0] row_r;
  logic       emit_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_r <= 1'b0;
      row_r  <= 2'd0;
    end else if (ctl_r[5].valid) begin
      emit_r <= 1'b1;
      row_r  <= 2'd0;
    end else if (emit_r) begin
      row_r  <= row_r + 2'd1;
      emit_r <= (row_r != 2'd3);
    end
  end

  logic [1:0] row_sel;
  assign row_sel = ctl_r[5].valid ? 2'd0 : row_r + 2'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= ctl_r[5].valid || (emit_r && row_r != 2'd3);
    end
  end

  always_ff @(posedge clk) begin
    out_row_index <= row_sel;
    out_elem_0    <= mat_r[row_sel][0];
    out_elem_1    <= mat_r[row_sel][1];
    out_elem_2    <= mat_r[row_sel][2];
    out_elem_3    <= mat_r[row_sel][3];
    out_last_row  <= (row_sel == 2'd3);
  end

  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> busy) else $error("busy not raised after start");
  a_last_on_row3: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_row == (out_row_index == 2'd3)))
    else $error("last row flag mismatch");
  a_row_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_row_index != 2'd3) |=> (out_valid && out_row_index == $past(out_row_index) + 2'd1))
    else $error("row beats not consecutive");

endmodule
